// ===== rtl/core/control_message_deframer_assert.svh =====
// assertion macros for the control message deframer
`ifndef CONTROL_MESSAGE_DEFRAMER_ASSERT_SVH
`define CONTROL_MESSAGE_DEFRAMER_ASSERT_SVH

// same-cycle implication, clocked on aclk, off during reset
`define CMD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define CMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cmd_pkg.sv =====
// types and constants of the control message deframer
package cmd_pkg;

    localparam int LENGTH_BITS = 24;

    typedef logic [LENGTH_BITS-1:0] len_t;
    typedef logic [2:0]             msg_type_t;

    localparam logic [7:0] MARKER_REQUEST = 8'h66;
    localparam logic [7:0] MARKER_ANSWER  = 8'h77;
    localparam logic [7:0] TYPE_FIRST     = 8'h65;
    localparam logic [7:0] TYPE_LAST      = 8'h6a;

    // header parser position, then payload pass-through
    typedef enum logic [2:0] {
        ST_MARK0,
        ST_MARK1,
        ST_TYPE,
        ST_LEN_HI,
        ST_LEN_MID,
        ST_LEN_LO,
        ST_PAYLOAD
    } hdr_state_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        msg_type_t  message_type;
        logic       last_of_message;
        logic       empty_message;
        logic       sync_error;
    } result_t;

endpackage

// ===== rtl/core/control_message_deframer.sv =====
// control message deframer: header parser and payload pass-through
//
// Takes one stream byte per cycle on the s_ channel while s_ready is high
// and splits the stream into messages (two marker bytes, a type byte, a
// 24-bit big-endian length, then the payload). A byte's result, if any, is
// registered and shows on the m_ channel in the cycle after the transaction;
// header bytes give no result except for a bad marker or type byte (sync
// error) and a zero length (one empty result). The single output register
// sets the rate: s_ready is high while that register is empty or being
// taken, so with m_ready held high the block sustains one byte per cycle.
module control_message_deframer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_stream_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_payload_byte,
    output cmd_pkg::msg_type_t   m_message_type,
    output logic                 m_last_of_message,
    output logic                 m_empty_message,
    output logic                 m_sync_error
);

    cmd_pkg::hdr_state_t state_reg, state_next;
    cmd_pkg::len_t       remaining_reg, remaining_next;
    cmd_pkg::msg_type_t  type_reg, type_next;
    cmd_pkg::result_t    result_reg, result_comb;
    logic                m_valid_reg;
    logic                res_valid;

    logic                s_fire;
    logic                is_marker;
    logic                type_ok;
    logic                payload_last;
    cmd_pkg::len_t       len_shift;

    // handshake: accept while the output slot is free or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // byte classification
    assign is_marker    = (s_stream_byte == cmd_pkg::MARKER_REQUEST)
                       || (s_stream_byte == cmd_pkg::MARKER_ANSWER);
    assign type_ok      = (s_stream_byte >= cmd_pkg::TYPE_FIRST)
                       && (s_stream_byte <= cmd_pkg::TYPE_LAST);
    assign payload_last = (remaining_reg <= cmd_pkg::len_t'(1));
    assign len_shift    = cmd_pkg::len_t'({remaining_reg, s_stream_byte});

    // next state
    always_comb begin
        state_next = state_reg;
        if (s_fire) begin
            case (state_reg)
                cmd_pkg::ST_MARK0:   state_next = is_marker ? cmd_pkg::ST_MARK1
                                                            : cmd_pkg::ST_MARK0;
                cmd_pkg::ST_MARK1:   state_next = is_marker ? cmd_pkg::ST_TYPE
                                                            : cmd_pkg::ST_MARK0;
                cmd_pkg::ST_TYPE:    state_next = type_ok ? cmd_pkg::ST_LEN_HI
                                                          : cmd_pkg::ST_MARK0;
                cmd_pkg::ST_LEN_HI:  state_next = cmd_pkg::ST_LEN_MID;
                cmd_pkg::ST_LEN_MID: state_next = cmd_pkg::ST_LEN_LO;
                cmd_pkg::ST_LEN_LO:  state_next = (len_shift == '0) ? cmd_pkg::ST_MARK0
                                                                    : cmd_pkg::ST_PAYLOAD;
                cmd_pkg::ST_PAYLOAD: state_next = payload_last ? cmd_pkg::ST_MARK0
                                                               : cmd_pkg::ST_PAYLOAD;
                default:             state_next = is_marker ? cmd_pkg::ST_MARK1
                                                            : cmd_pkg::ST_MARK0;
            endcase
        end
    end

    // length counter and message type
    always_comb begin
        remaining_next = remaining_reg;
        type_next      = type_reg;
        if (s_fire) begin
            case (state_reg)
                cmd_pkg::ST_TYPE: begin
                    if (type_ok) begin
                        type_next = cmd_pkg::msg_type_t'(s_stream_byte - cmd_pkg::TYPE_FIRST);
                    end
                end
                cmd_pkg::ST_LEN_HI:  remaining_next = cmd_pkg::len_t'(s_stream_byte);
                cmd_pkg::ST_LEN_MID: remaining_next = len_shift;
                cmd_pkg::ST_LEN_LO:  remaining_next = len_shift;
                cmd_pkg::ST_PAYLOAD: begin
                    remaining_next = payload_last ? '0
                                                  : remaining_reg - cmd_pkg::len_t'(1);
                end
                default: ;
            endcase
        end
    end

    // result of the current byte
    always_comb begin
        res_valid   = 1'b0;
        result_comb = '0;
        case (state_reg)
            cmd_pkg::ST_MARK1: begin
                res_valid              = !is_marker;
                result_comb.sync_error = 1'b1;
            end
            cmd_pkg::ST_TYPE: begin
                res_valid              = !type_ok;
                result_comb.sync_error = 1'b1;
            end
            cmd_pkg::ST_LEN_HI,
            cmd_pkg::ST_LEN_MID: ;
            cmd_pkg::ST_LEN_LO: begin
                res_valid                   = (len_shift == '0);
                result_comb.message_type    = type_reg;
                result_comb.last_of_message = 1'b1;
                result_comb.empty_message   = 1'b1;
            end
            cmd_pkg::ST_PAYLOAD: begin
                res_valid                   = 1'b1;
                result_comb.payload_byte    = s_stream_byte;
                result_comb.message_type    = type_reg;
                result_comb.last_of_message = payload_last;
            end
            default: begin
                // first marker position, also unused codes
                res_valid              = !is_marker;
                result_comb.sync_error = 1'b1;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cmd_pkg::ST_MARK0;
            remaining_reg <= '0;
            type_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            remaining_reg <= remaining_next;
            type_reg      <= type_next;
            if (s_ready) begin
                m_valid_reg <= s_fire && res_valid;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (s_fire && res_valid) begin
            result_reg <= result_comb;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_payload_byte    = result_reg.payload_byte;
    assign m_message_type    = result_reg.message_type;
    assign m_last_of_message = result_reg.last_of_message;
    assign m_empty_message   = result_reg.empty_message;
    assign m_sync_error      = result_reg.sync_error;

    // checks
`include "control_message_deframer_assert.svh"

    `CMD_ASSERT_NOW(a_sync_err_clean,
        m_valid_reg && result_reg.sync_error,
        !result_reg.last_of_message && !result_reg.empty_message
            && (result_reg.message_type == '0) && (result_reg.payload_byte == '0),
        "sync error result carries message fields")
    `CMD_ASSERT_NOW(a_empty_is_last,
        m_valid_reg && result_reg.empty_message,
        result_reg.last_of_message,
        "empty result not marked last")
    `CMD_ASSERT_NOW(a_type_range,
        m_valid_reg && !result_reg.sync_error,
        result_reg.message_type <= cmd_pkg::msg_type_t'(5),
        "message type out of range")
    `CMD_ASSERT_NOW(a_payload_count,
        state_reg == cmd_pkg::ST_PAYLOAD,
        remaining_reg != '0,
        "payload state with no bytes left")
    `CMD_ASSERT_NEXT(a_zero_len_result,
        s_fire && (state_reg == cmd_pkg::ST_LEN_LO) && (len_shift == '0),
        m_valid_reg && result_reg.empty_message && (state_reg == cmd_pkg::ST_MARK0),
        "zero length gave no empty result")

endmodule
